// ===== src/tacr_pkg.sv =====
// shared types, constants and helpers for the touch adc command responder
package tacr_pkg;

    localparam int FIFO_LIMIT = 8;
    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = PTR_W + 1;
    localparam int EFF_LIMIT  = (FIFO_LIMIT < RING_DEPTH) ? FIFO_LIMIT : RING_DEPTH - 1;

    localparam int COEF_W  = 32;
    localparam int COORD_W = 12;
    localparam int HOST_W  = 13;
    localparam int WORD_W  = 16;
    localparam int PROD_W  = COEF_W + COORD_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 16;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);
    localparam logic [COORD_W-1:0]      RAW_MIN    = COORD_W'(1);
    localparam logic [COORD_W-1:0]      RAW_MAX    = COORD_W'(4095);

    localparam logic [COORD_W-1:0] X_LIMIT_RST = COORD_W'(799);
    localparam logic [COORD_W-1:0] Y_LIMIT_RST = COORD_W'(599);

    localparam logic [7:0] CTL_NONE = 8'h00;
    localparam logic [7:0] CTL_Y0   = 8'h90;
    localparam logic [7:0] CTL_Y1   = 8'h93;
    localparam logic [7:0] CTL_X0   = 8'hD0;
    localparam logic [7:0] CTL_X1   = 8'hD3;
    localparam logic [7:0] CTL_AUX  = 8'hE0;

    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_COEF_XX  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COEF_XY  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COEF_XOF = 3'd2;
    localparam logic [CFG_AW-1:0] REG_COEF_YX  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_COEF_YY  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_COEF_YOF = 3'd5;
    localparam logic [CFG_AW-1:0] REG_X_LIMIT  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_Y_LIMIT  = 3'd7;

    typedef enum logic [2:0] {
        FUNC_CMD_WRITE    = 3'd0,
        FUNC_SAMPLE_READ  = 3'd1,
        FUNC_POINTER      = 3'd2,
        FUNC_CAPTURE_LOST = 3'd3,
        FUNC_PEN_READ     = 3'd4
    } t_func;

    typedef logic [PTR_W-1:0] t_ptr;

    typedef struct packed {
        logic               valid;
        logic               push;
        logic               pop;
        t_ptr               addr;
        logic               map_en;
        logic               sel_x;
        logic               overrun;
        logic               bad;
        logic               pen_irq;
        logic               pen_up;
    } t_ctl;

    typedef struct packed {
        t_ctl               ctl;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
    } t_s1;

    typedef struct packed {
        t_ctl                      ctl;
        logic signed [PROD_W-1:0]  prod_a;
        logic signed [PROD_W-1:0]  prod_b;
        logic signed [COEF_W-1:0]  offset;
    } t_s2;

    typedef struct packed {
        logic valid;
        logic pop;
        logic overrun;
        logic bad;
        logic pen_irq;
        logic pen_up;
    } t_res;

    function automatic t_ptr ptr_inc(input t_ptr p);
        ptr_inc = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

// ===== src/tacr_ram.sv =====
// generic single write port ram with registered read
module tacr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tacr_front.sv =====
// input register and command decode with pointer, pen and fifo index state
module tacr_front import tacr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_in_valid,
    input  logic [2:0]                i_func,
    input  logic [15:0]               i_cmd,
    input  logic signed [HOST_W-1:0]  i_host_x,
    input  logic signed [HOST_W-1:0]  i_host_y,
    input  logic                      i_pen_down,
    input  logic [COORD_W-1:0]        i_x_limit,
    input  logic [COORD_W-1:0]        i_y_limit,
    output t_s1                       o_s1
);

    logic                     r_in_valid;
    logic [2:0]               r_func;
    logic [7:0]               r_ctl;
    logic signed [HOST_W-1:0] r_hx;
    logic signed [HOST_W-1:0] r_hy;
    logic                     r_pen;

    logic [7:0]         r_last, n_last;
    logic               r_irq_en, n_irq_en;
    logic               r_touched, n_touched;
    logic [COORD_W-1:0] r_px, n_px;
    logic [COORD_W-1:0] r_py, n_py;
    t_ptr               r_head, n_head;
    t_ptr               r_tail, n_tail;
    t_s1                r_s1, n_s1;

    logic             fire;
    logic             ctl_ok;
    logic [CNT_W-1:0] cnt_raw;
    logic [CNT_W-1:0] cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_in_valid;
        end
        if (i_adv) begin
            r_func <= i_func;
            r_ctl  <= i_cmd[7:0];
            r_hx   <= i_host_x;
            r_hy   <= i_host_y;
            r_pen  <= i_pen_down;
        end
    end

    assign fire   = i_adv && r_in_valid;
    assign ctl_ok = (r_ctl == CTL_NONE) || (r_ctl == CTL_Y0) || (r_ctl == CTL_Y1) ||
                    (r_ctl == CTL_X0) || (r_ctl == CTL_X1) || (r_ctl == CTL_AUX);

    always_comb begin
        cnt_raw = CNT_W'({1'b0, r_tail}) - CNT_W'({1'b0, r_head});
        cnt     = (r_head > r_tail) ? cnt_raw + CNT_W'(RING_DEPTH) : cnt_raw;
    end

    always_comb begin
        n_last    = r_last;
        n_irq_en  = r_irq_en;
        n_touched = r_touched;
        n_px      = r_px;
        n_py      = r_py;
        n_head    = r_head;
        n_tail    = r_tail;
        n_s1      = '0;
        n_s1.px   = r_px;
        n_s1.py   = r_py;

        case (t_func'(r_func))
            FUNC_CMD_WRITE: begin
                if (!ctl_ok) begin
                    n_s1.ctl.bad = 1'b1;
                end else begin
                    n_last = r_ctl;
                    if (r_ctl != CTL_NONE) begin
                        n_irq_en = !r_ctl[0];
                    end
                    if (cnt >= CNT_W'(EFF_LIMIT)) begin
                        n_s1.ctl.overrun = 1'b1;
                    end else begin
                        n_s1.ctl.push   = 1'b1;
                        n_s1.ctl.addr   = r_tail;
                        n_tail          = ptr_inc(r_tail);
                        n_s1.ctl.sel_x  = (r_last == CTL_X0) || (r_last == CTL_X1);
                        n_s1.ctl.map_en = r_touched &&
                            ((r_last == CTL_X0) || (r_last == CTL_X1) ||
                             (r_last == CTL_Y0) || (r_last == CTL_Y1));
                    end
                end
            end
            FUNC_SAMPLE_READ: begin
                if (r_head != r_tail) begin
                    n_s1.ctl.pop  = 1'b1;
                    n_s1.ctl.addr = r_head;
                    n_head        = ptr_inc(r_head);
                end
            end
            FUNC_POINTER: begin
                if (r_hx[HOST_W-1]) begin
                    n_px = '0;
                end else if (r_hx[COORD_W-1:0] > i_x_limit) begin
                    n_px = i_x_limit;
                end else begin
                    n_px = r_hx[COORD_W-1:0];
                end
                if (r_hy[HOST_W-1]) begin
                    n_py = '0;
                end else if (r_hy[COORD_W-1:0] > i_y_limit) begin
                    n_py = i_y_limit;
                end else begin
                    n_py = r_hy[COORD_W-1:0];
                end
                n_touched = r_pen;
            end
            FUNC_CAPTURE_LOST: begin
                n_touched = 1'b0;
            end
            FUNC_PEN_READ: begin
                n_touched = r_touched;
            end
            default: begin
                n_touched = r_touched;
            end
        endcase

        n_s1.ctl.valid   = r_in_valid;
        n_s1.ctl.pen_irq = n_irq_en && n_touched;
        n_s1.ctl.pen_up  = !n_touched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= CTL_NONE;
            r_irq_en  <= 1'b0;
            r_touched <= 1'b0;
            r_px      <= '0;
            r_py      <= '0;
            r_head    <= '0;
            r_tail    <= '0;
        end else if (fire) begin
            r_last    <= n_last;
            r_irq_en  <= n_irq_en;
            r_touched <= n_touched;
            r_px      <= n_px;
            r_py      <= n_py;
            r_head    <= n_head;
            r_tail    <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

// ===== src/tacr_map.sv =====
// affine raw map: product stage, then sum, round and clamp into the fifo write
module tacr_map import tacr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  t_s1                       i_s1,
    input  logic signed [COEF_W-1:0]  i_coef_xx,
    input  logic signed [COEF_W-1:0]  i_coef_xy,
    input  logic signed [COEF_W-1:0]  i_coef_xof,
    input  logic signed [COEF_W-1:0]  i_coef_yx,
    input  logic signed [COEF_W-1:0]  i_coef_yy,
    input  logic signed [COEF_W-1:0]  i_coef_yof,
    output logic                      o_ram_we,
    output t_ptr                      o_ram_waddr,
    output logic [WORD_W-1:0]         o_ram_wdata,
    output logic                      o_ram_re,
    output t_ptr                      o_ram_raddr,
    output t_res                      o_res
);

    t_s2 r_s2, n_s2;
    t_res r_res;

    logic signed [COEF_W-1:0]       gain_a;
    logic signed [COEF_W-1:0]       gain_b;
    logic signed [ACC_W-1:0]        acc;
    logic signed [ACC_W-FRAC_W-1:0] whole;
    logic [COORD_W-1:0]             raw;

    always_comb begin
        gain_a        = i_s1.ctl.sel_x ? i_coef_xx : i_coef_yx;
        gain_b        = i_s1.ctl.sel_x ? i_coef_xy : i_coef_yy;
        n_s2.ctl      = i_s1.ctl;
        n_s2.offset   = i_s1.ctl.sel_x ? i_coef_xof : i_coef_yof;
        n_s2.prod_a   = PROD_W'(gain_a * $signed({1'b0, i_s1.px}));
        n_s2.prod_b   = PROD_W'(gain_b * $signed({1'b0, i_s1.py}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.ctl.valid <= 1'b0;
        end else if (i_adv) begin
            r_s2 <= n_s2;
        end
    end

    // halves round away from zero; any negative sum clamps to the minimum
    always_comb begin
        acc   = ACC_W'(r_s2.prod_a) + ACC_W'(r_s2.prod_b) + ACC_W'(r_s2.offset) + ROUND_HALF;
        whole = acc[ACC_W-1:FRAC_W];
        if (acc[ACC_W-1] || (whole == '0)) begin
            raw = RAW_MIN;
        end else if (|whole[ACC_W-FRAC_W-2:COORD_W]) begin
            raw = RAW_MAX;
        end else begin
            raw = whole[COORD_W-1:0];
        end
    end

    assign o_ram_we    = i_adv && r_s2.ctl.valid && r_s2.ctl.push;
    assign o_ram_waddr = r_s2.ctl.addr;
    assign o_ram_wdata = r_s2.ctl.map_en ? WORD_W'(raw) : '0;
    assign o_ram_re    = i_adv && r_s2.ctl.valid && r_s2.ctl.pop;
    assign o_ram_raddr = r_s2.ctl.addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else if (i_adv) begin
            r_res.valid   <= r_s2.ctl.valid;
            r_res.pop     <= r_s2.ctl.pop;
            r_res.overrun <= r_s2.ctl.overrun;
            r_res.bad     <= r_s2.ctl.bad;
            r_res.pen_irq <= r_s2.ctl.pen_irq;
            r_res.pen_up  <= r_s2.ctl.pen_up;
        end
    end

    assign o_res = r_res;

endmodule

// ===== src/touch_adc_command_responder.sv =====
// top level of the touch adc command responder
//
//  channel   valid        stall        payload
//  input     i_in_valid   o_in_stall   i_func i_cmd i_host_x i_host_y i_pen_down
//  output    o_out_valid  i_out_stall  o_read_data o_overrun o_bad_control o_pen_irq o_pen_up
//  config    i_cfg_we     -            i_cfg_addr i_cfg_data
//
// one item per cycle while the output is not stalled; each result is registered through the stages below
// stages: input register, decode and state update, gain products, sum/clamp and fifo access
// the fifo read data register is the output register for read_data
// a stalled result freezes all stages together, so the input stalls in the same cycle
// synchronous active-low reset clears the state and the pipeline valid bits
module touch_adc_command_responder import tacr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [2:0]                i_func,
    input  logic [15:0]               i_cmd,
    input  logic signed [HOST_W-1:0]  i_host_x,
    input  logic signed [HOST_W-1:0]  i_host_y,
    input  logic                      i_pen_down,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [WORD_W-1:0]         o_read_data,
    output logic                      o_overrun,
    output logic                      o_bad_control,
    output logic                      o_pen_irq,
    output logic                      o_pen_up,
    input  logic                      i_cfg_we,
    input  logic [CFG_AW-1:0]         i_cfg_addr,
    input  logic [COEF_W-1:0]         i_cfg_data
);

    logic signed [COEF_W-1:0] r_coef_xx;
    logic signed [COEF_W-1:0] r_coef_xy;
    logic signed [COEF_W-1:0] r_coef_xof;
    logic signed [COEF_W-1:0] r_coef_yx;
    logic signed [COEF_W-1:0] r_coef_yy;
    logic signed [COEF_W-1:0] r_coef_yof;
    logic [COORD_W-1:0]       r_x_limit;
    logic [COORD_W-1:0]       r_y_limit;

    logic              adv;
    t_s1               s1;
    t_res              res;
    logic              ram_we;
    t_ptr              ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    t_ptr              ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_xx  <= '0;
            r_coef_xy  <= '0;
            r_coef_xof <= '0;
            r_coef_yx  <= '0;
            r_coef_yy  <= '0;
            r_coef_yof <= '0;
            r_x_limit  <= X_LIMIT_RST;
            r_y_limit  <= Y_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_COEF_XX:  r_coef_xx  <= i_cfg_data;
                REG_COEF_XY:  r_coef_xy  <= i_cfg_data;
                REG_COEF_XOF: r_coef_xof <= i_cfg_data;
                REG_COEF_YX:  r_coef_yx  <= i_cfg_data;
                REG_COEF_YY:  r_coef_yy  <= i_cfg_data;
                REG_COEF_YOF: r_coef_yof <= i_cfg_data;
                REG_X_LIMIT:  r_x_limit  <= i_cfg_data[COORD_W-1:0];
                REG_Y_LIMIT:  r_y_limit  <= i_cfg_data[COORD_W-1:0];
                default: begin
                    r_x_limit <= r_x_limit;
                end
            endcase
        end
    end

    assign adv        = !(res.valid && i_out_stall);
    assign o_in_stall = !adv;

    tacr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_cmd      (i_cmd),
        .i_host_x   (i_host_x),
        .i_host_y   (i_host_y),
        .i_pen_down (i_pen_down),
        .i_x_limit  (r_x_limit),
        .i_y_limit  (r_y_limit),
        .o_s1       (s1)
    );

    tacr_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_s1        (s1),
        .i_coef_xx   (r_coef_xx),
        .i_coef_xy   (r_coef_xy),
        .i_coef_xof  (r_coef_xof),
        .i_coef_yx   (r_coef_yx),
        .i_coef_yy   (r_coef_yy),
        .i_coef_yof  (r_coef_yof),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .o_res       (res)
    );

    tacr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid   = res.valid;
    assign o_read_data   = res.pop ? ram_rdata : '0;
    assign o_overrun     = res.overrun;
    assign o_bad_control = res.bad;
    assign o_pen_irq     = res.pen_irq;
    assign o_pen_up      = res.pen_up;

endmodule

// ===== src/tacr_checker.sv =====
// port-level checks on the touch adc command responder, bound to the top level
module tacr_props import tacr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [WORD_W-1:0] o_read_data,
    input logic              o_overrun,
    input logic              o_bad_control,
    input logic              o_pen_irq,
    input logic              o_pen_up
);

    // at most one kind of result per item: data, overrun or bad control
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_overrun || o_bad_control) |->
            (o_read_data == '0) && !(o_overrun && o_bad_control))
        else $error("read data or flags overlap in one item");

    // mapped samples never exceed twelve bits
    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_read_data[WORD_W-1:COORD_W] == '0))
        else $error("read data beyond raw range");

    // interrupt only while the pen is down
    a_irq_pen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pen_irq |-> !o_pen_up)
        else $error("pen interrupt with pen up");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled item changed");

endmodule

bind touch_adc_command_responder tacr_props u_tacr_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_read_data   (o_read_data),
    .o_overrun     (o_overrun),
    .o_bad_control (o_bad_control),
    .o_pen_irq     (o_pen_irq),
    .o_pen_up      (o_pen_up)
);
